// ===== rtl/core/windowed_min_cost_path_assert.svh =====
// Assertion macros shared by the windowed min-cost path RTL.
`ifndef WINDOWED_MIN_COST_PATH_ASSERT_SVH
`define WINDOWED_MIN_COST_PATH_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check, off while reset is asserted
`define WMCP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define WMCP_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WMCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define WMCP_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/wmcp_pkg.sv =====
// Shared types and constants for the windowed min-cost path block.
`timescale 1ns / 1ps
package wmcp_pkg;

	localparam int WINDOW_MAX_DEF = 4;
	localparam int WEIGHT_W       = 32;
	localparam int COST_W         = 48;
	localparam int REACH_W        = 3;

	localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(1);

	// One input beat
	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                first;
		logic                last;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              final_res;
	} result_t;

endpackage

// ===== rtl/core/wmcp_window.sv =====
// Cost window: recent-cost history, windowed minimum and saturating add.
`timescale 1ns / 1ps
`include "windowed_min_cost_path_assert.svh"
module wmcp_window
	import wmcp_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [REACH_W-1:0]  reach,
	input  item_t               item,
	input  logic                advance,
	output logic [COST_W-1:0]   cost
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = (CNT_W > REACH_W) ? CNT_W : REACH_W;

	logic [COST_W-1:0] recent_q [WINDOW_MAX];
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  fill_eff;
	logic [CNT_W-1:0]  fill_nxt;
	logic [IDX_W-1:0]  reach_eff;
	logic [COST_W-1:0] best;
	logic [COST_W:0]   sum;

	// Clamp reach into 1..WINDOW_MAX
	always_comb begin
		reach_eff = IDX_W'(reach);
		if (reach == '0) begin
			reach_eff = IDX_W'(1);
		end else if (IDX_W'(reach) > IDX_W'(WINDOW_MAX)) begin
			reach_eff = IDX_W'(WINDOW_MAX);
		end
	end

	// A first beat restarts the path with an empty window
	assign fill_eff = item.first ? '0 : fill_q;

	// Take the minimum over the live part of the window
	always_comb begin
		best = recent_q[0];
		for (int i = 1; i < WINDOW_MAX; i++) begin
			if (IDX_W'(i) < reach_eff && CNT_W'(i) < fill_eff && recent_q[i] < best) begin
				best = recent_q[i];
			end
		end
	end

	// Add the weight, saturate on carry out
	assign sum = {1'b0, best} + (COST_W + 1)'(item.weight);

	always_comb begin
		if (fill_eff == '0) begin
			cost = COST_W'(item.weight);
		end else if (sum[COST_W]) begin
			cost = '1;
		end else begin
			cost = sum[COST_W-1:0];
		end
	end

	// Grow the fill count up to the window size, drop it after a last beat
	always_comb begin
		if (item.last) begin
			fill_nxt = '0;
		end else if (fill_eff < CNT_W'(WINDOW_MAX)) begin
			fill_nxt = fill_eff + CNT_W'(1);
		end else begin
			fill_nxt = fill_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (advance) begin
			fill_q <= fill_nxt;
		end
	end

	// Shift the new cost into the history; entries past fill_q are never read
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = WINDOW_MAX - 1; i > 0; i--) begin
				recent_q[i] <= recent_q[i-1];
			end
			recent_q[0] <= cost;
		end
	end

	`WMCP_ASSERT_NORST(a_fill_bound, clk, fill_q <= CNT_W'(WINDOW_MAX), "fill count past window size")
	`WMCP_ASSERT(a_last_clears, clk, arst_n, (advance && item.last) |=> fill_q == '0, "fill count not cleared after last beat")
	`WMCP_ASSERT(a_fill_grows, clk, arst_n, (advance && !item.last && !item.first && fill_q < CNT_W'(WINDOW_MAX)) |=> fill_q == $past(fill_q) + CNT_W'(1), "fill count did not advance")

endmodule

// ===== rtl/core/windowed_min_cost_path.sv =====
// An accepted beat is registered in the input stage, then written into the result queue, whose head
// drives the result port.
// Throughput: one beat per cycle while the result queue has room; each cost is computed combinationally.
// A two-entry result queue keeps input flowing while a result waits.
// Reset (arst_n low, asynchronous): pipeline and queue empty, window empty,
// reach back to 1. The configuration port is always ready.
`timescale 1ns / 1ps
`include "windowed_min_cost_path_assert.svh"
module windowed_min_cost_path
	import wmcp_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [REACH_W-1:0]  reach,
	// input items
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic                first,
	input  logic                last,
	// results
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COST_W-1:0]   cost,
	output logic                final_res
);

	localparam logic [1:0] QDEPTH = 2'd2;

	logic [REACH_W-1:0] reach_q;
	item_t              item_s1;
	logic               valid_s1;
	logic               adv;
	logic               pop;
	logic [COST_W-1:0]  cost_s1;
	result_t            res_new;
	result_t            res0_q;
	result_t            res1_q;
	logic [1:0]         cnt_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= REACH_RESET;
		end else if (cfg_valid) begin
			reach_q <= reach;
		end
	end

	// Advance the input stage when the queue has room
	assign adv      = valid_s1 && (cnt_q != QDEPTH);
	assign in_ready = !valid_s1 || adv;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{weight: weight, first: first, last: last};
		end
	end

	wmcp_window #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.reach   (reach_q),
		.item    (item_s1),
		.advance (adv),
		.cost    (cost_s1)
	);

	assign res_new = '{cost: cost_s1, final_res: item_s1.last};

	// Result queue: occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case ({adv, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Result queue: data, head in res0_q
	always_ff @(posedge clk) begin
		unique case ({adv, pop})
			2'b10: begin
				if (cnt_q == '0) begin
					res0_q <= res_new;
				end else begin
					res1_q <= res_new;
				end
			end
			2'b01: begin
				res0_q <= res1_q;
			end
			2'b11: begin
				res0_q <= res_new;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = (cnt_q != '0);
	assign cost      = res0_q.cost;
	assign final_res = res0_q.final_res;

	`WMCP_ASSERT_NORST(a_cnt_range, clk, cnt_q <= QDEPTH, "result queue overfilled")
	`WMCP_ASSERT(a_adv_shows, clk, arst_n, adv |=> out_valid, "advanced beat did not reach the result port")
	`WMCP_ASSERT(a_pop_drains, clk, arst_n, (pop && !adv) |=> cnt_q == $past(cnt_q) - 2'd1, "queue count wrong after pop")

endmodule

// ===== dv/windowed_min_cost_path_checker.sv =====
// Scoreboard for windowed_min_cost_path: predicts every cost beat and checks the result port.
`timescale 1ns / 1ps
module windowed_min_cost_path_checker
	import wmcp_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [REACH_W-1:0]  reach,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic                first,
	input  logic                last,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [COST_W-1:0]   cost,
	input  logic                final_res,
	output int unsigned         fail_count,
	output int unsigned         pending_results,
	output int unsigned         results_checked
);

	localparam logic [COST_W-1:0] COST_TOP = '1;

	// Predicted path state: costs of the latest positions, newest first
	logic [COST_W-1:0] path_window [WINDOW_MAX];
	int unsigned       window_fill;
	logic [REACH_W-1:0] reach_setting;
	result_t           cost_due_q [$];
	result_t           oldest_due;

	// Print one line per mismatch (first few only) and count every one
	task automatic report_mismatch(input string what, input logic [COST_W-1:0] got,
		input logic [COST_W-1:0] want);
		if (fail_count < 40)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	// Number of window entries a jump may come from
	function automatic int unsigned jump_span();
		int unsigned span;
		span = reach_setting;
		if (span < 1)
			span = 1;
		if (span > WINDOW_MAX)
			span = WINDOW_MAX;
		if (span > window_fill)
			span = window_fill;
		return span;
	endfunction

	// Work out the cost of one position, advance the window and queue the beat
	task automatic advance_path(input logic [WEIGHT_W-1:0] w, input logic f, input logic l);
		logic [COST_W-1:0] best;
		logic [COST_W:0]   sum;
		result_t           due;
		int unsigned       span;
		if (f)
			window_fill = 0;
		if (window_fill == 0) begin
			due.cost = COST_W'(w);
		end else begin
			span = jump_span();
			best = path_window[0];
			for (int i = 1; i < span; i++)
				if (path_window[i] < best)
					best = path_window[i];
			sum = {1'b0, best} + (COST_W + 1)'(w);
			// saturate at the top of the cost range
			due.cost = sum[COST_W] ? COST_TOP : sum[COST_W-1:0];
		end
		for (int i = WINDOW_MAX - 1; i > 0; i--)
			path_window[i] = path_window[i-1];
		path_window[0] = due.cost;
		if (window_fill < WINDOW_MAX)
			window_fill++;
		// a last position closes the path
		if (l)
			window_fill = 0;
		due.final_res = l;
		cost_due_q = {cost_due_q, due};
	endtask

	// Watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_MAX; i++)
				path_window[i] = '0;
			window_fill = 0;
			reach_setting = REACH_RESET;
			cost_due_q.delete();
			fail_count = 0;
			results_checked = 0;
			pending_results <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				reach_setting = reach;
			if (in_valid && in_ready)
				advance_path(weight, first, last);
			// compare each result beat with the oldest prediction
			if (out_valid && out_ready) begin
				if (cost_due_q.size() == 0) begin
					report_mismatch("result beat with nothing expected", cost, '0);
				end else begin
					oldest_due = cost_due_q.pop_front();
					if (cost !== oldest_due.cost)
						report_mismatch("cost", cost, oldest_due.cost);
					if (final_res !== oldest_due.final_res)
						report_mismatch("final_res", COST_W'(final_res),
							COST_W'(oldest_due.final_res));
					results_checked++;
				end
			end
			pending_results <= cost_due_q.size();
		end
	end

endmodule

// ===== dv/windowed_min_cost_path_tb.sv =====
// Testbench top for windowed_min_cost_path: stimulus, idling, stall pressure and verdict.
`timescale 1ns / 1ps
module windowed_min_cost_path_tb;
	import wmcp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned TOP_PATH_LEN = 64;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [REACH_W-1:0]  reach;
	logic                in_valid;
	logic                in_ready;
	logic [WEIGHT_W-1:0] weight;
	logic                first;
	logic                last;
	logic                out_valid;
	logic                out_ready;
	logic [COST_W-1:0]   cost;
	logic                final_res;

	int unsigned fail_count;
	int unsigned pending_results;
	int unsigned results_checked;
	int unsigned beats_sent = 0;
	int unsigned cycle_count = 0;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_request;

	windowed_min_cost_path dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.reach     (reach),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.weight    (weight),
		.first     (first),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cost      (cost),
		.final_res (final_res)
	);

	windowed_min_cost_path_checker cost_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.reach           (reach),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.weight          (weight),
		.first           (first),
		.last            (last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cost            (cost),
		.final_res       (final_res),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.results_checked (results_checked)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("windowed_min_cost_path_tb NOT OK");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one input beat after a random gap and hold it until accepted
	task automatic send_beat(input logic [WEIGHT_W-1:0] w, input logic f, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		weight   <= w;
		first    <= f;
		last     <= l;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// Stop offering and wait until every predicted beat has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write reach once the block is idle
	task automatic write_reach(input logic [REACH_W-1:0] val);
		drain_results();
		cfg_valid <= 1'b1;
		reach     <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Weights biased toward the edges of the range
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: return WEIGHT_W'($urandom_range(255));
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	// Mostly well-formed paths with random weights; some flags scrambled
	task automatic run_paths(input int unsigned n);
		int unsigned sent;
		int unsigned len;
		logic        f;
		logic        l;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			for (int unsigned p = 0; p < len && sent < n; p++) begin
				f = (p == 0);
				l = (p == len - 1);
				if ($urandom_range(99) < 15)
					f = 1'($urandom_range(1));
				if ($urandom_range(99) < 15)
					l = 1'($urandom_range(1));
				send_beat(pick_weight(), f, l);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		reach         = '0;
		in_valid      = 1'b0;
		weight        = '0;
		first         = 1'b0;
		last          = 1'b0;
		out_ready     = 1'b0;
		hold_request  = 1'b0;
		send_idle_pct = 26;
		recv_idle_pct = 86;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset reach: empty window, restart after last, one-position path, mid-path restart
		send_beat(32'd5, 1'b0, 1'b0);
		send_beat(32'd0, 1'b0, 1'b0);
		send_beat('1, 1'b0, 1'b0);
		send_beat(32'd7, 1'b0, 1'b1);
		send_beat(32'd9, 1'b0, 1'b0);
		send_beat(32'd3, 1'b1, 1'b1);
		send_beat(32'd2, 1'b1, 1'b0);
		send_beat('1, 1'b0, 1'b0);
		send_beat(32'd1, 1'b1, 1'b0);
		send_beat(32'd4, 1'b0, 1'b1);

		// Reach zero acts as one
		write_reach(3'd0);
		send_beat(32'd10, 1'b1, 1'b0);
		send_beat(32'd1, 1'b0, 1'b0);
		send_beat(32'd2, 1'b0, 1'b0);
		send_beat(32'd3, 1'b0, 1'b1);

		// Reach above the window clamps to the window
		write_reach(3'd7);
		send_beat(32'd100, 1'b1, 1'b0);
		send_beat(32'd1, 1'b0, 1'b0);
		send_beat(32'd50, 1'b0, 1'b0);
		send_beat(32'd60, 1'b0, 1'b0);
		send_beat(32'd70, 1'b0, 1'b0);
		send_beat(32'd80, 1'b0, 1'b0);
		send_beat(32'd5, 1'b0, 1'b1);

		// Full reach with extreme weights
		write_reach(3'd4);
		send_beat(32'd0, 1'b1, 1'b0);
		send_beat('1, 1'b0, 1'b0);
		send_beat('1, 1'b0, 1'b0);
		send_beat(32'd0, 1'b0, 1'b1);

		// Random paths over three idling profiles and every reach value
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				write_reach(REACH_W'(((phase * 4 + blk) * 3 + 2) % 8));
				if (phase == 2 && blk == 1) begin
					// fill the block while results are held off
					hold_request = 1'b1;
					run_paths(150);
				end else if (phase == 1 && blk == 2) begin
					run_paths(65);
					drain_results();
					run_paths(80);
				end else begin
					run_paths(145);
				end
			end
		end

		// One long path of top weights builds up large costs
		write_reach(3'd1);
		send_beat('1, 1'b1, 1'b0);
		repeat (TOP_PATH_LEN - 1) send_beat('1, 1'b0, 1'b0);
		send_beat(pick_weight(), 1'b0, 1'b0);
		send_beat(32'd0, 1'b0, 1'b0);
		send_beat(pick_weight(), 1'b0, 1'b1);

		drain_results();
		repeat (8) @(posedge clk);

		$display("covered %0d beats, %0d results checked, reach settings 0..7,",
			beats_sent, results_checked);
		$display("path edge cases, a full-queue stall and a %0d-position top-weight path",
			TOP_PATH_LEN);
		if (fail_count == 0) begin
			$display("windowed_min_cost_path_tb OK");
		end else begin
			$display("windowed_min_cost_path_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/wmcp_pkg.sv
rtl/core/wmcp_window.sv
rtl/core/windowed_min_cost_path.sv
dv/windowed_min_cost_path_checker.sv
dv/windowed_min_cost_path_tb.sv
